// File: src/jlhl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jlhl_pkg;

  localparam int unsigned POS_W        = 13;
  localparam int unsigned CNT_W        = 9;
  localparam int unsigned TOKEN_BUDGET = 256;
  localparam int unsigned LINE_MAX     = 4096;

  // Slot layout of one bundle, in line order
  localparam int unsigned FAIL_N      = 5;   // defaults for a broken word, handled byte
  localparam int unsigned FFAIL_N     = 4;   // defaults for a broken word, line end
  localparam int unsigned SLOT_FAIL0  = 0;
  localparam int unsigned SLOT_END    = 5;   // token closed by this byte
  localparam int unsigned SLOT_HSP    = 6;   // whitespace after a held string
  localparam int unsigned SLOT_START  = 7;   // one-byte token opened by this byte
  localparam int unsigned SLOT_FFAIL0 = 8;
  localparam int unsigned SLOT_FLUSH  = 12;  // token closed by the line end
  localparam int unsigned SLOT_FHSP   = 13;
  localparam int unsigned NSLOT       = 14;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef logic [POS_W-1:0] pos_t;

  localparam pos_t             LINE_MAX_P = POS_W'(LINE_MAX);
  localparam logic [POS_W:0]   LINE_MAX_X = (POS_W + 1)'(LINE_MAX);
  localparam logic [CNT_W-1:0] CNT_MAX    = CNT_W'(TOKEN_BUDGET);
  localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(TOKEN_BUDGET - 1);

  typedef enum logic [2:0] {
    KIND_DEFAULT = 3'd0,
    KIND_KEY     = 3'd1,
    KIND_STRING  = 3'd2,
    KIND_NUMBER  = 3'd3,
    KIND_KEYWORD = 3'd4,
    KIND_PUNCT   = 3'd5
  } tok_kind_e;

  typedef struct packed {
    pos_t      start;
    pos_t      stop;
    tok_kind_e kind;
  } tok_t;

  typedef struct packed {
    logic [NSLOT-1:0] mask;
    logic             line_end;
    tok_t [NSLOT-1:0] tok;
  } bundle_t;

  typedef struct packed {
    logic    valid;
    bundle_t data;
  } q_head_t;

  localparam logic [1:0] WORD_TRUE  = 2'd0;
  localparam logic [1:0] WORD_FALSE = 2'd1;
  localparam logic [1:0] WORD_NULL  = 2'd2;

  localparam logic [39:0] KW_TRUE  = {"true", 8'h00};
  localparam logic [39:0] KW_FALSE = "false";
  localparam logic [39:0] KW_NULL  = {"null", 8'h00};

  function automatic pos_t sat_add(pos_t x, logic [2:0] k);
    logic [POS_W:0] s;
    pos_t           r;
    s = {1'b0, x} + {{(POS_W - 2){1'b0}}, k};
    r = (s > LINE_MAX_X) ? LINE_MAX_P : s[POS_W-1:0];
    return r;
  endfunction

  function automatic logic [2:0] kw_len(logic [1:0] w);
    return (w == WORD_FALSE) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [7:0] kw_char(logic [1:0] w, logic [2:0] i);
    logic [39:0] txt;
    logic [2:0]  sel;
    case (w)
      WORD_TRUE:  txt = KW_TRUE;
      WORD_FALSE: txt = KW_FALSE;
      default:    txt = KW_NULL;
    endcase
    sel = 3'd4 - i;
    return txt[{sel, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

// File: src/jlhl_front.sv
`timescale 1ns / 1ps
`default_nettype none

module jlhl_front import jlhl_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       take_i,
  input  wire logic [7:0] text_byte_i,
  input  wire logic       line_end_i,
  output logic            push_o,
  output bundle_t         bundle_o
);

  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_SPACE  = 3'd1;
  localparam logic [2:0] MODE_STRING = 3'd2;
  localparam logic [2:0] MODE_HELD   = 3'd3;
  localparam logic [2:0] MODE_HSP    = 3'd4;
  localparam logic [2:0] MODE_NUMBER = 3'd5;
  localparam logic [2:0] MODE_WORD   = 3'd6;
  localparam logic [2:0] MODE_CHAR   = 3'd7;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UPE    = 8'h45;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LOWE   = 8'h65;
  localparam logic [7:0] CH_LOWF   = 8'h66;
  localparam logic [7:0] CH_LOWN   = 8'h6E;
  localparam logic [7:0] CH_LOWT   = 8'h74;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  logic [2:0] mode_q, mode_d;
  pos_t       pos_q, pos_d;
  pos_t       tstart_q, tstart_d;
  pos_t       hend_q, hend_d;
  pos_t       hsp_q, hsp_d;
  logic       esc_q, esc_d;
  logic [2:0] fill_q, fill_d;
  logic [1:0] widx_q, widx_d;
  logic [1:0] rem_q, rem_d;

  logic       is_ws, is_quote, is_bslash, is_colon, is_digit, is_word, is_num;
  logic       is_kwl, is_punct;
  logic [1:0] st_rem;
  logic       st_emit;
  logic [2:0] st_mode;
  logic [1:0] st_widx;
  tok_kind_e  st_kind;
  pos_t       p1;
  logic       do_start, fail;
  bundle_t    bnd;

  // Byte classes and what a fresh token would look like
  always_comb begin
    is_ws     = text_byte_i inside {CH_SPACE, CH_TAB, CH_CR};
    is_quote  = (text_byte_i == CH_QUOTE);
    is_bslash = (text_byte_i == CH_BSLASH);
    is_colon  = (text_byte_i == CH_COLON);
    is_digit  = text_byte_i inside {[8'h30:8'h39]};
    is_word   = text_byte_i inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], CH_UNDER};
    is_num    = text_byte_i inside {[8'h30:8'h39], CH_DOT, CH_LOWE, CH_UPE, CH_PLUS, CH_MINUS};
    is_kwl    = text_byte_i inside {CH_LOWT, CH_LOWF, CH_LOWN};
    is_punct  = text_byte_i inside {CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK,
                                    CH_COLON, CH_COMMA};
    if (!text_byte_i[7]) begin
      st_rem = 2'd0;
    end else if (text_byte_i[7:5] == 3'b110) begin
      st_rem = 2'd1;
    end else if (text_byte_i[7:4] == 4'b1110) begin
      st_rem = 2'd2;
    end else if (text_byte_i[7:3] == 5'b11110) begin
      st_rem = 2'd3;
    end else begin
      st_rem = 2'd0;
    end
    st_widx = (text_byte_i == CH_LOWT) ? WORD_TRUE :
              (text_byte_i == CH_LOWF) ? WORD_FALSE : WORD_NULL;
    st_emit = 1'b0;
    st_kind = KIND_DEFAULT;
    if (is_ws) begin
      st_mode = MODE_SPACE;
    end else if (is_quote) begin
      st_mode = MODE_STRING;
    end else if (is_digit || text_byte_i == CH_MINUS) begin
      st_mode = MODE_NUMBER;
    end else if (is_kwl) begin
      st_mode = MODE_WORD;
    end else if (is_punct) begin
      st_mode = MODE_IDLE;
      st_emit = 1'b1;
      st_kind = KIND_PUNCT;
    end else if (st_rem == 2'd0) begin
      st_mode = MODE_IDLE;
      st_emit = 1'b1;
    end else begin
      st_mode = MODE_CHAR;
    end
  end

  assign p1 = sat_add(pos_q, 3'd1);

  always_comb begin
    mode_d   = mode_q;
    pos_d    = p1;
    tstart_d = tstart_q;
    hend_d   = hend_q;
    hsp_d    = hsp_q;
    esc_d    = esc_q;
    fill_d   = fill_q;
    widx_d   = widx_q;
    rem_d    = rem_q;
    do_start = 1'b0;
    fail     = 1'b0;
    bnd      = '0;
    bnd.line_end = line_end_i;
    for (int i = 0; i < FAIL_N; i++) begin
      bnd.tok[SLOT_FAIL0 + i] = '{start: sat_add(tstart_q, 3'(i)),
                                  stop: sat_add(tstart_q, 3'(i + 1)),
                                  kind: KIND_DEFAULT};
    end
    bnd.tok[SLOT_START] = '{start: pos_q, stop: p1, kind: st_kind};

    case (mode_q)
      MODE_IDLE: begin
        do_start = 1'b1;
      end
      MODE_SPACE: begin
        if (!is_ws) begin
          bnd.tok[SLOT_END]  = '{start: tstart_q, stop: pos_q, kind: KIND_DEFAULT};
          bnd.mask[SLOT_END] = 1'b1;
          do_start = 1'b1;
        end
      end
      MODE_STRING: begin
        if (esc_q) begin
          esc_d = 1'b0;
        end else if (is_bslash) begin
          esc_d = 1'b1;
        end else if (is_quote) begin
          hend_d = p1;
          mode_d = MODE_HELD;
        end
      end
      MODE_HELD, MODE_HSP: begin
        if (is_ws) begin
          if (mode_q == MODE_HELD) begin
            hsp_d  = pos_q;
            mode_d = MODE_HSP;
          end
        end else begin
          bnd.tok[SLOT_END]  = '{start: tstart_q, stop: hend_q,
                                kind: is_colon ? KIND_KEY : KIND_STRING};
          bnd.mask[SLOT_END] = 1'b1;
          bnd.tok[SLOT_HSP]  = '{start: hsp_q, stop: pos_q, kind: KIND_DEFAULT};
          bnd.mask[SLOT_HSP] = (mode_q == MODE_HSP);
          do_start = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (!is_num) begin
          bnd.tok[SLOT_END]  = '{start: tstart_q, stop: pos_q, kind: KIND_NUMBER};
          bnd.mask[SLOT_END] = 1'b1;
          do_start = 1'b1;
        end
      end
      MODE_CHAR: begin
        rem_d = rem_q - 2'd1;
        if (rem_q == 2'd1) begin
          bnd.tok[SLOT_END]  = '{start: tstart_q, stop: p1, kind: KIND_DEFAULT};
          bnd.mask[SLOT_END] = 1'b1;
          mode_d = MODE_IDLE;
        end
      end
      MODE_WORD: begin
        if (fill_q < kw_len(widx_q)) begin
          if (text_byte_i == kw_char(widx_q, fill_q)) begin
            fill_d = fill_q + 3'd1;
          end else begin
            fail = 1'b1;
          end
        end else if (is_word) begin
          fail = 1'b1;
        end else begin
          bnd.tok[SLOT_END]  = '{start: tstart_q, stop: sat_add(tstart_q, kw_len(widx_q)),
                                kind: KIND_KEYWORD};
          bnd.mask[SLOT_END] = 1'b1;
          fill_d   = 3'd0;
          do_start = 1'b1;
        end
      end
      default: begin
        do_start = 1'b1;
      end
    endcase

    // A broken word leaves one default token per buffered letter
    if (fail) begin
      for (int i = 0; i < FAIL_N; i++) begin
        if (3'(i) < fill_q) begin
          bnd.mask[SLOT_FAIL0 + i] = 1'b1;
        end
      end
      fill_d   = 3'd0;
      do_start = 1'b1;
    end

    if (do_start) begin
      mode_d   = st_mode;
      tstart_d = pos_q;
      bnd.mask[SLOT_START] = st_emit;
      if (is_quote) begin
        esc_d = 1'b0;
      end
      if (is_kwl) begin
        widx_d = st_widx;
        fill_d = 3'd1;
      end
      if (st_mode == MODE_CHAR) begin
        rem_d = st_rem;
      end
    end

    // Line end: close whatever is open, then return to the start of a line
    if (line_end_i) begin
      for (int i = 0; i < FFAIL_N; i++) begin
        bnd.tok[SLOT_FFAIL0 + i] = '{start: sat_add(tstart_d, 3'(i)),
                                     stop: sat_add(tstart_d, 3'(i + 1)),
                                     kind: KIND_DEFAULT};
      end
      bnd.tok[SLOT_FHSP] = '{start: hsp_d, stop: p1, kind: KIND_DEFAULT};
      case (mode_d)
        MODE_WORD: begin
          if (fill_d < kw_len(widx_d)) begin
            for (int i = 0; i < FFAIL_N; i++) begin
              if (3'(i) < fill_d) begin
                bnd.mask[SLOT_FFAIL0 + i] = 1'b1;
              end
            end
          end else begin
            bnd.tok[SLOT_FLUSH]  = '{start: tstart_d,
                                    stop: sat_add(tstart_d, kw_len(widx_d)),
                                    kind: KIND_KEYWORD};
            bnd.mask[SLOT_FLUSH] = 1'b1;
          end
        end
        MODE_SPACE, MODE_CHAR: begin
          bnd.tok[SLOT_FLUSH]  = '{start: tstart_d, stop: p1, kind: KIND_DEFAULT};
          bnd.mask[SLOT_FLUSH] = 1'b1;
        end
        MODE_STRING: begin
          bnd.tok[SLOT_FLUSH]  = '{start: tstart_d, stop: p1, kind: KIND_STRING};
          bnd.mask[SLOT_FLUSH] = 1'b1;
        end
        MODE_NUMBER: begin
          bnd.tok[SLOT_FLUSH]  = '{start: tstart_d, stop: p1, kind: KIND_NUMBER};
          bnd.mask[SLOT_FLUSH] = 1'b1;
        end
        MODE_HELD, MODE_HSP: begin
          bnd.tok[SLOT_FLUSH]  = '{start: tstart_d, stop: hend_d, kind: KIND_STRING};
          bnd.mask[SLOT_FLUSH] = 1'b1;
          bnd.mask[SLOT_FHSP]  = (mode_d == MODE_HSP);
        end
        default: begin
        end
      endcase
      mode_d   = MODE_IDLE;
      pos_d    = '0;
      tstart_d = '0;
      hend_d   = '0;
      hsp_d    = '0;
      esc_d    = 1'b0;
      fill_d   = 3'd0;
      rem_d    = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      pos_q    <= '0;
      tstart_q <= '0;
      hend_q   <= '0;
      hsp_q    <= '0;
      esc_q    <= 1'b0;
      fill_q   <= 3'd0;
      widx_q   <= WORD_TRUE;
      rem_q    <= 2'd0;
    end else if (take_i) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      tstart_q <= tstart_d;
      hend_q   <= hend_d;
      hsp_q    <= hsp_d;
      esc_q    <= esc_d;
      fill_q   <= fill_d;
      widx_q   <= widx_d;
      rem_q    <= rem_d;
    end
  end

  assign push_o   = take_i && ((|bnd.mask) || line_end_i);
  assign bundle_o = bnd;

endmodule

`default_nettype wire

// File: src/jlhl_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module jlhl_queue import jlhl_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire bundle_t data_i,
  input  wire logic    pop_i,
  output logic         full_o,
  output q_head_t      head_o
);

  bundle_t             entry_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

  assign full_o       = (cnt_q == QCNT_W'(QDEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.data  = entry_q[rd_ptr_q];

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != QCNT_W'(QDEPTH)))
    else $error("bundle queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != '0))
    else $error("bundle queue read while empty");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("bundle queue count out of range");
`endif

endmodule

`default_nettype wire

// File: src/jlhl_back.sv
`timescale 1ns / 1ps
`default_nettype none

module jlhl_back import jlhl_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire q_head_t head_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output pos_t         tok_start_o,
  output pos_t         tok_end_o,
  output logic [2:0]   tok_kind_o,
  output logic         last_of_item_o,
  output logic         line_done_o
);

  logic [NSLOT-1:0] done_q, done_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  tok_t             tok_q;
  logic             last_q, line_q;

  logic [NSLOT-1:0] rem, lowbit;
  tok_t             tok_sel;
  logic             load_ok, emit, last;

  always_comb begin
    rem     = head_i.data.mask & ~done_q;
    lowbit  = rem & (~rem + 1'b1);
    tok_sel = '0;
    for (int i = 0; i < NSLOT; i++) begin
      if (lowbit[i]) begin
        tok_sel = head_i.data.tok[i];
      end
    end
    load_ok = !out_valid_q || !out_stall_i;
    last    = ((rem & ~lowbit) == '0) || (count_q == CNT_LAST);

    emit        = 1'b0;
    pop_o       = 1'b0;
    done_d      = done_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (head_i.valid) begin
      if ((count_q >= CNT_MAX) || (rem == '0)) begin
        // drop: token budget spent or nothing left in this bundle
        pop_o  = 1'b1;
        done_d = '0;
        if (head_i.data.line_end) begin
          count_d = '0;
        end
      end else if (load_ok) begin
        emit        = 1'b1;
        out_valid_d = 1'b1;
        if (last) begin
          pop_o   = 1'b1;
          done_d  = '0;
          count_d = head_i.data.line_end ? '0 : count_q + 1'b1;
        end else begin
          done_d  = done_q | lowbit;
          count_d = count_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q      <= done_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      tok_q  <= tok_sel;
      last_q <= last;
      line_q <= last && head_i.data.line_end;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign tok_start_o    = tok_q.start;
  assign tok_end_o      = tok_q.stop;
  assign tok_kind_o     = tok_q.kind;
  assign last_of_item_o = last_q;
  assign line_done_o    = line_q;

`ifndef SYNTHESIS
  a_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_MAX)
    else $error("token count beyond budget");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (tok_start_o <= tok_end_o))
    else $error("token ends before it starts");

  a_done_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_i.valid |-> (done_q == '0))
    else $error("sent-slot mask left over with no bundle");

  a_done_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_i.valid |-> ((done_q & ~head_i.data.mask) == '0))
    else $error("sent-slot mask outside bundle mask");
`endif

endmodule

`default_nettype wire

// File: src/json_line_highlight_lexer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+------------------------------------------
// in       | sink      | in_valid_i / in_stall_o | text_byte_i, line_end_i
// out      | source    | out_valid_o / out_stall_i | tok_start_o, tok_end_o, tok_kind_o,
//          |           |                        | last_of_item_o, line_done_o
//
// Cycles: one byte transfer per cycle while the bundle queue has room; the back end
//   sends the tokens of a bundle one at a time, so a byte that closes several tokens
//   holds the back end through each of them and the queue absorbs the burst.
// Path: a byte's bundle is written into the queue, then the back end registers its first token for output.
// Reset: rst_ni is asynchronous, active low; clears lexer state, queue pointers and count, and out_valid_o.
// Stalls: the input stalls only when the four-entry queue is full; the output
//   register holds its token while out_stall_i is high.

module json_line_highlight_lexer import jlhl_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] text_byte_i,
  input  wire logic       line_end_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [12:0]     tok_start_o,
  output logic [12:0]     tok_end_o,
  output logic [2:0]      tok_kind_o,
  output logic            last_of_item_o,
  output logic            line_done_o
);

  logic    q_full;
  logic    take;
  logic    push;
  logic    pop;
  bundle_t bundle;
  q_head_t head;

  // Accept a byte whenever the queue can take its bundle
  assign in_stall_o = q_full;
  assign take       = in_valid_i && !q_full;

  // Front end: classify each byte and collect every token it closes into one bundle
  jlhl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .text_byte_i (text_byte_i),
    .line_end_i  (line_end_i),
    .push_o      (push),
    .bundle_o    (bundle)
  );

  // Short queue decouples byte intake from token output
  jlhl_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (bundle),
    .pop_i  (pop),
    .full_o (q_full),
    .head_o (head)
  );

  // Back end: drain bundles one token per transfer and enforce the token budget
  jlhl_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .tok_start_o    (tok_start_o),
    .tok_end_o      (tok_end_o),
    .tok_kind_o     (tok_kind_o),
    .last_of_item_o (last_of_item_o),
    .line_done_o    (line_done_o)
  );

endmodule

`default_nettype wire
